// ===== sv/udp_socket_demux_table_defines.svh =====
// Assertion macros for the UDP socket table.
// Taken in by the top level only; relies on clk and rst_n being in scope.
`ifndef UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH
`define UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define UDP_SDT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udp_socket_demux_table: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define UDP_SDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udp_socket_demux_table: next-cycle check failed");

`endif

// ===== sv/udp_sdt_pkg.sv =====
// Shared types and constants for the UDP socket table.
// No dependencies; used by every module of the block.
package udp_sdt_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 5;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;
    localparam int STATUS_W = 2;

    // Stream data widths (whole bytes)
    localparam int IN_DATA_W  = 88;
    localparam int IN_PAD_W   = IN_DATA_W - (SLOT_W + IP_W + PORT_W + IP_W);
    localparam int OUT_DATA_W = 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - SLOT_W;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_OPEN    = 2'd0,
        OP_CLOSE   = 2'd1,
        OP_CONNECT = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_INVALID = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    // One table entry, also used as the lookup key
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   peer_ip;
    } entry_t;

endpackage

// ===== sv/udp_sdt_ram.sv =====
// Entry store for the UDP socket table: one write port, one registered read port.
// Depends on udp_sdt_pkg for the entry type.
module udp_sdt_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  udp_sdt_pkg::entry_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output udp_sdt_pkg::entry_t rd_data
);

    udp_sdt_pkg::entry_t mem [DEPTH];
    udp_sdt_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/udp_sdt_cmp.sv =====
// Shared match unit: compares one stored entry against the lookup key.
// Depends on udp_sdt_pkg for the entry type.
module udp_sdt_cmp (
    input  logic                pending,
    input  logic                entry_valid,
    input  udp_sdt_pkg::entry_t entry,
    input  udp_sdt_pkg::entry_t key,
    output logic                hit
);

    logic addr_eq;
    logic port_eq;

    // 48-bit equality, split by field
    assign addr_eq = (entry.peer_ip == key.peer_ip);
    assign port_eq = (entry.port == key.port);
    assign hit     = pending && entry_valid && addr_eq && port_eq;

endmodule

// ===== sv/udp_socket_demux_table.sv =====
// UDP socket table: open, close and connect, and lookup by a linear scan.
// Close, connect and a non-local lookup are resolved in the execute state into the output register;
// open scans the valid bits from slot 1 up (one valid bit tested per cycle); lookup scans the entries
// (one entry read and compared per cycle through the shared match unit).
// One item in flight; the next beat is taken once the result has been taken.
// Reset (rst_n low, async): all slots free, local_ip zero; entries stay unwritten.
`include "udp_socket_demux_table_defines.svh"

module udp_socket_demux_table #(
    parameter int SLOTS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration: local_ip
    input  logic                                   cfg_wr_en,
    input  logic [udp_sdt_pkg::IP_W-1:0]           cfg_wr_data,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: slot[4:0], peer_ip[36:5], port[52:37], dest_ip[84:53], zero pad
    input  logic [udp_sdt_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: operation[1:0]
    input  logic [udp_sdt_pkg::OP_W-1:0]           s_tuser,
    // output stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: found_slot[4:0], zero pad
    output logic [udp_sdt_pkg::OUT_DATA_W-1:0]     m_tdata,
    // tuser: status[1:0]
    output logic [udp_sdt_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] FIRST_IDX = IW'(1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_OPEN = 4'b0100,
        S_LOOK = 4'b1000
    } state_t;

    // Unpacked input beat
    logic [udp_sdt_pkg::SLOT_W-1:0] in_slot;
    logic [udp_sdt_pkg::IP_W-1:0]   in_peer_ip;
    logic [udp_sdt_pkg::PORT_W-1:0] in_port;
    logic [udp_sdt_pkg::IP_W-1:0]   in_dest_ip;
    logic                           accept;

    // Registers
    state_t                         state_reg, state_next;
    logic [udp_sdt_pkg::IP_W-1:0]   local_ip_reg;
    udp_sdt_pkg::op_t               op_reg;
    logic [udp_sdt_pkg::SLOT_W-1:0] slot_reg;
    udp_sdt_pkg::entry_t            key_reg;
    logic                           dest_hit_reg;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic                           issue_reg, issue_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]                  cmp_idx_reg, cmp_idx_next;
    logic [SLOTS-1:0]               valid_reg, valid_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    udp_sdt_pkg::status_t           status_reg, status_next;
    logic [udp_sdt_pkg::SLOT_W-1:0] found_reg, found_next;

    // Memory and match unit signals
    logic                           ram_wr_en;
    logic [IW-1:0]                  ram_wr_addr;
    udp_sdt_pkg::entry_t            ram_wr_data;
    logic                           ram_rd_en;
    udp_sdt_pkg::entry_t            ram_rd_data;
    logic                           hit;
    logic [IW-1:0]                  slot_idx;
    logic                           slot_usable;

    assign in_slot    = s_tdata[4:0];
    assign in_peer_ip = s_tdata[36:5];
    assign in_port    = s_tdata[52:37];
    assign in_dest_ip = s_tdata[84:53];

    // Ready when idle and the output register is empty or being emptied
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign slot_idx    = IW'(slot_reg);
    assign slot_usable = (slot_reg != '0) && (32'(slot_reg) < SLOTS) && valid_reg[slot_idx];

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            local_ip_reg <= cfg_wr_data;
        end
    end

    // Captured item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= udp_sdt_pkg::op_t'(s_tuser);
            slot_reg     <= in_slot;
            key_reg      <= '{port: in_port, peer_ip: in_peer_ip};
            dest_hit_reg <= (in_dest_ip == local_ip_reg);
        end
    end

    // Entry store
    udp_sdt_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Shared match unit
    udp_sdt_cmp u_cmp (
        .pending     (cmp_vld_reg),
        .entry_valid (valid_reg[cmp_idx_reg]),
        .entry       (ram_rd_data),
        .key         (key_reg),
        .hit         (hit)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg;
        ram_wr_data   = key_reg;
        ram_rd_en     = 1'b0;

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next   = S_EXEC;
                    idx_next     = FIRST_IDX;
                    issue_next   = 1'b1;
                    cmp_vld_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    udp_sdt_pkg::OP_OPEN:
                    begin
                        state_next = S_OPEN;
                    end
                    udp_sdt_pkg::OP_CLOSE:
                    begin
                        state_next    = S_IDLE;
                        m_tvalid_next = 1'b1;
                        found_next    = '0;
                        if (slot_usable)
                        begin
                            valid_next[slot_idx] = 1'b0;
                            status_next          = udp_sdt_pkg::ST_OK;
                        end
                        else
                        begin
                            status_next = udp_sdt_pkg::ST_INVALID;
                        end
                    end
                    udp_sdt_pkg::OP_CONNECT:
                    begin
                        state_next    = S_IDLE;
                        m_tvalid_next = 1'b1;
                        found_next    = '0;
                        ram_wr_addr   = slot_idx;
                        ram_wr_data   = key_reg;
                        if (slot_usable)
                        begin
                            ram_wr_en   = 1'b1;
                            status_next = udp_sdt_pkg::ST_OK;
                        end
                        else
                        begin
                            status_next = udp_sdt_pkg::ST_INVALID;
                        end
                    end
                    default:
                    begin
                        // lookup: scan only when the packet is for this host
                        if (dest_hit_reg)
                        begin
                            state_next = S_LOOK;
                        end
                        else
                        begin
                            state_next    = S_IDLE;
                            m_tvalid_next = 1'b1;
                            status_next   = udp_sdt_pkg::ST_NOMATCH;
                            found_next    = '0;
                        end
                    end
                endcase
            end
            S_OPEN:
            begin
                // one valid bit tested per cycle, lowest first
                if (!valid_reg[idx_reg])
                begin
                    valid_next[idx_reg] = 1'b1;
                    ram_wr_en           = 1'b1;
                    ram_wr_addr         = idx_reg;
                    ram_wr_data         = '0;
                    state_next          = S_IDLE;
                    m_tvalid_next       = 1'b1;
                    status_next         = udp_sdt_pkg::ST_OK;
                    found_next          = udp_sdt_pkg::SLOT_W'(idx_reg);
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    status_next   = udp_sdt_pkg::ST_NOFREE;
                    found_next    = '0;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_LOOK:
            begin
                // issue stage: read the next entry
                ram_rd_en    = issue_reg;
                cmp_vld_next = issue_reg;
                cmp_idx_next = idx_reg;
                if (issue_reg)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                // compare stage: entry read in the previous cycle
                if (hit)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    status_next   = udp_sdt_pkg::ST_OK;
                    found_next    = udp_sdt_pkg::SLOT_W'(cmp_idx_reg);
                end
                else if (!issue_reg && !cmp_vld_reg)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    status_next   = udp_sdt_pkg::ST_NOMATCH;
                    found_next    = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            issue_reg    <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
        end
    end

    // Scan index and result payload
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{udp_sdt_pkg::OUT_PAD_W{1'b0}}, found_reg};
    assign m_tuser  = status_reg;

    // Checks
    `UDP_SDT_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC)
    `UDP_SDT_ASSERT_NOW(a_busy_out_empty, state_reg != S_IDLE, !m_tvalid_reg)
    `UDP_SDT_ASSERT_NOW(a_fail_no_slot, m_tvalid_reg && status_reg != udp_sdt_pkg::ST_OK, found_reg == '0)
    `UDP_SDT_ASSERT_NEXT(a_open_marks, state_reg == S_OPEN && !valid_reg[idx_reg], valid_reg[$past(idx_reg)])

endmodule

// ===== bench/udp_sdt_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UDP socket table: watches the configuration port and both streams,
// predicts each reply from its own copy of the table and compares it on arrival.
// Depends on udp_sdt_pkg for field widths, operation and status codes.
module udp_sdt_checker #(
    parameter int SLOTS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [udp_sdt_pkg::IP_W-1:0]       cfg_wr_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // tdata: slot[4:0], peer_ip[36:5], port[52:37], dest_ip[84:53], zero pad
    input  logic [udp_sdt_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: operation[1:0]
    input  logic [udp_sdt_pkg::OP_W-1:0]       s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: found_slot[4:0], zero pad
    input  logic [udp_sdt_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: status[1:0]
    input  logic [udp_sdt_pkg::STATUS_W-1:0]   m_tuser,
    output int                                 fail_count,
    output int                                 outstanding
);

    localparam int REPORT_LIMIT = 10;
    localparam int SLOT_W       = udp_sdt_pkg::SLOT_W;
    localparam int IP_W         = udp_sdt_pkg::IP_W;
    localparam int PORT_W       = udp_sdt_pkg::PORT_W;

    typedef struct packed {
        udp_sdt_pkg::status_t status;
        logic [SLOT_W-1:0]    slot;
    } socket_reply_t;

    // Shadow of the table and of the local address
    logic              slot_open [SLOTS];
    logic [IP_W-1:0]   slot_peer [SLOTS];
    logic [PORT_W-1:0] slot_port [SLOTS];
    logic [IP_W-1:0]   host_ip;

    socket_reply_t expected_replies [$];

    // Applies one request to the shadow table and returns the reply it should give
    function automatic socket_reply_t predict_socket_op(
        udp_sdt_pkg::op_t op, logic [SLOT_W-1:0] slot, logic [IP_W-1:0] peer,
        logic [PORT_W-1:0] port, logic [IP_W-1:0] dest);
        socket_reply_t reply;
        int unsigned   idx;
        bit            usable;
        reply.status = udp_sdt_pkg::ST_OK;
        reply.slot   = '0;
        idx    = 32'(slot);
        usable = (idx >= 1) && (idx < SLOTS) && slot_open[idx];
        case (op)
            udp_sdt_pkg::OP_OPEN:
            begin
                reply.status = udp_sdt_pkg::ST_NOFREE;
                for (int i = 1; i < SLOTS; i++)
                begin
                    if (!slot_open[i])
                    begin
                        slot_open[i] = 1'b1;
                        slot_peer[i] = '0;
                        slot_port[i] = '0;
                        reply.status = udp_sdt_pkg::ST_OK;
                        reply.slot   = i[SLOT_W-1:0];
                        break;
                    end
                end
            end
            udp_sdt_pkg::OP_CLOSE:
            begin
                if (usable)
                    slot_open[idx] = 1'b0;
                else
                    reply.status = udp_sdt_pkg::ST_INVALID;
            end
            udp_sdt_pkg::OP_CONNECT:
            begin
                if (usable)
                begin
                    slot_peer[idx] = peer;
                    slot_port[idx] = port;
                end
                else
                    reply.status = udp_sdt_pkg::ST_INVALID;
            end
            default:
            begin
                // lookup: lowest open slot whose peer and port both match
                reply.status = udp_sdt_pkg::ST_NOMATCH;
                if (dest == host_ip)
                begin
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        if (slot_open[i] && slot_peer[i] == peer && slot_port[i] == port)
                        begin
                            reply.status = udp_sdt_pkg::ST_OK;
                            reply.slot   = i[SLOT_W-1:0];
                            break;
                        end
                    end
                end
            end
        endcase
        return reply;
    endfunction

    task automatic log_failure(string what, socket_reply_t want, socket_reply_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s: expected status %0d slot %0d, got status %0d slot %0d",
                     $time, what, want.status, want.slot, got.status, got.slot);
    endtask

    // Sampled at the rising edge; replies are checked before new requests are queued
    always @(posedge clk)
    begin : watch_channels
        socket_reply_t want;
        socket_reply_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_open[i] = 1'b0;
                slot_peer[i] = '0;
                slot_port[i] = '0;
            end
            host_ip = '0;
            expected_replies.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = udp_sdt_pkg::status_t'(m_tuser);
                got.slot   = m_tdata[SLOT_W-1:0];
                if (expected_replies.size() == 0)
                begin
                    want = '0;
                    log_failure("reply beat with nothing pending", want, got);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot)
                        log_failure("reply mismatch", want, got);
                end
            end
            if (cfg_wr_en)
                host_ip = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_replies.push_back(predict_socket_op(
                    udp_sdt_pkg::op_t'(s_tuser),
                    s_tdata[SLOT_W-1:0],
                    s_tdata[SLOT_W +: IP_W],
                    s_tdata[SLOT_W+IP_W +: PORT_W],
                    s_tdata[SLOT_W+IP_W+PORT_W +: IP_W]));
            outstanding = expected_replies.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the UDP socket table testbench: clock, reset, request and reply traffic, verdict.
// Depends on udp_sdt_pkg, the udp_socket_demux_table RTL and udp_sdt_checker.
module tb;

    localparam int          SLOTS         = 32;
    localparam int          SETTLE_CYCLES = SLOTS + 4;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          BACKLOG_HOLD  = 250;
    localparam int          PHASES        = 5;
    localparam int          PHASE_ITEMS   = 246;
    localparam logic [31:0] FIRST_HOST_IP = 32'h0A00_0001;
    localparam int          SLOT_W        = udp_sdt_pkg::SLOT_W;
    localparam int          IP_W          = udp_sdt_pkg::IP_W;
    localparam int          PORT_W        = udp_sdt_pkg::PORT_W;

    logic                                  clk         = 1'b0;
    logic                                  rst_n       = 1'b0;
    logic                                  cfg_wr_en   = 1'b0;
    logic [IP_W-1:0]                       cfg_wr_data = '0;
    logic                                  s_tvalid    = 1'b0;
    logic                                  s_tready;
    logic [udp_sdt_pkg::IN_DATA_W-1:0]     s_tdata     = '0;
    logic [udp_sdt_pkg::OP_W-1:0]          s_tuser     = '0;
    logic                                  m_tvalid;
    logic                                  m_tready    = 1'b0;
    logic [udp_sdt_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic [udp_sdt_pkg::STATUS_W-1:0]      m_tuser;

    int          fail_count;
    int          outstanding;
    bit          tx_pace = 1'b1;
    bit          rx_pace = 1'b1;
    logic [31:0] host_ip = '0;
    logic [31:0] peer_pool [6];
    logic [15:0] port_pool [6];
    int unsigned op_count [4];
    int unsigned ip_settings = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    udp_socket_demux_table #(
        .SLOTS (SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    udp_sdt_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog: ends the run once nothing has moved for too long
    always @(posedge clk)
    begin : watchdog
        int unsigned quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reply sink: random hold-offs per beat, and two long stalls to back up the input
    initial
    begin : reply_sink
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_pace ? $urandom_range(0, 14) : 0;
            if (taken == 300 || taken == 900)
                hold = BACKLOG_HOLD;
            if (hold != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    // Mostly low slots, which the lowest-free allocation keeps open
    function automatic logic [SLOT_W-1:0] pick_slot();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return SLOT_W'($urandom_range(1, 8));
        else if (r < 9)
            return SLOT_W'($urandom_range(1, SLOTS - 1));
        return SLOT_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [IP_W-1:0] pick_peer();
        if ($urandom_range(0, 4) != 0)
            return peer_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        if ($urandom_range(0, 4) != 0)
            return port_pool[$urandom_range(0, 5)];
        return PORT_W'($urandom_range(0, 65535));
    endfunction

    // Offers one request beat after a random gap and returns at the accepting edge
    task automatic offer_request(udp_sdt_pkg::op_t op, logic [SLOT_W-1:0] slot,
                                 logic [IP_W-1:0] peer, logic [PORT_W-1:0] port,
                                 logic [IP_W-1:0] dest);
        int unsigned gap;
        gap = tx_pace ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{udp_sdt_pkg::IN_PAD_W{1'b0}}, dest, port, peer, slot};
        op_count[int'(op)]++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_local_ip(logic [IP_W-1:0] ip);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ip;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        host_ip = ip;
        ip_settings++;
    endtask

    // Stop offering, wait for every reply, then let the block go quiet
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random request; weights in percent, lookup takes the remainder
    task automatic random_request(int unsigned open_w, int unsigned close_w,
                                  int unsigned connect_w);
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        if (r < open_w)
            offer_request(udp_sdt_pkg::OP_OPEN, SLOT_W'($urandom_range(0, 31)), $urandom,
                          PORT_W'($urandom_range(0, 65535)), $urandom);
        else if (r < open_w + close_w)
            offer_request(udp_sdt_pkg::OP_CLOSE, pick_slot(), $urandom,
                          PORT_W'($urandom_range(0, 65535)), $urandom);
        else if (r < open_w + close_w + connect_w)
            offer_request(udp_sdt_pkg::OP_CONNECT, pick_slot(), pick_peer(), pick_port(),
                          $urandom);
        else
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
                offer_request(udp_sdt_pkg::OP_LOOKUP, SLOT_W'($urandom_range(0, 31)),
                              pick_peer(), pick_port(), host_ip);
            else if (k < 8)
                // one address bit off the local address
                offer_request(udp_sdt_pkg::OP_LOOKUP, SLOT_W'($urandom_range(0, 31)),
                              pick_peer(), pick_port(),
                              host_ip ^ (32'h1 << $urandom_range(0, 31)));
            else
                offer_request(udp_sdt_pkg::OP_LOOKUP, SLOT_W'($urandom_range(0, 31)),
                              $urandom, PORT_W'($urandom_range(0, 65535)), $urandom);
        end
    endtask

    initial
    begin : stimulus
        logic [IP_W-1:0] phase_ip   [PHASES];
        int unsigned     open_w     [PHASES];
        int unsigned     close_w    [PHASES];
        int unsigned     connect_w  [PHASES];
        bit              phase_pace [PHASES];

        // Address pools: the all-zero pair matches freshly opened slots
        peer_pool[0] = '0;
        peer_pool[1] = '1;
        port_pool[0] = '0;
        port_pool[1] = '1;
        for (int i = 2; i < 6; i++)
        begin
            peer_pool[i] = $urandom;
            port_pool[i] = PORT_W'($urandom_range(0, 65535));
        end

        // Phases: fill, balanced without idling, drain, fill, balanced
        phase_ip   = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom, FIRST_HOST_IP};
        open_w     = '{55, 25,  8, 50, 25};
        close_w    = '{ 5, 25, 50, 10, 25};
        connect_w  = '{15, 20, 12, 15, 20};
        phase_pace = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_local_ip(FIRST_HOST_IP);

        // Directed: empty table, bad slots, lowest-free reuse, cleared entries, priority
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'h0,         16'h0,    FIRST_HOST_IP);
        offer_request(udp_sdt_pkg::OP_CLOSE,   5'd0,  32'h0,         16'h0,    32'h0);
        offer_request(udp_sdt_pkg::OP_CONNECT, 5'd5,  32'h1111_2222, 16'h3333, 32'h0);
        offer_request(udp_sdt_pkg::OP_OPEN,    5'd0,  32'h0,         16'h0,    32'h0);
        offer_request(udp_sdt_pkg::OP_OPEN,    5'd31, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'h0,         16'h0,    FIRST_HOST_IP);
        offer_request(udp_sdt_pkg::OP_CONNECT, 5'd1,  32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        offer_request(udp_sdt_pkg::OP_CONNECT, 5'd2,  32'h1234_5678, 16'h0,    32'h0);
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'hFFFF_FFFF, 16'hFFFF, FIRST_HOST_IP);
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'hFFFF_FFFF, 16'hFFFF, ~FIRST_HOST_IP);
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'hFFFF_FFFF, 16'hFFFE, FIRST_HOST_IP);
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'h1234_5678, 16'h0,    FIRST_HOST_IP);
        offer_request(udp_sdt_pkg::OP_CLOSE,   5'd31, 32'h0,         16'h0,    32'h0);
        offer_request(udp_sdt_pkg::OP_CLOSE,   5'd1,  32'h0,         16'h0,    32'h0);
        offer_request(udp_sdt_pkg::OP_CLOSE,   5'd1,  32'h0,         16'h0,    32'h0);
        offer_request(udp_sdt_pkg::OP_CONNECT, 5'd1,  32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'hFFFF_FFFF, 16'hFFFF, FIRST_HOST_IP);
        offer_request(udp_sdt_pkg::OP_OPEN,    5'd0,  32'h0,         16'h0,    32'h0);
        offer_request(udp_sdt_pkg::OP_CONNECT, 5'd0,  32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        offer_request(udp_sdt_pkg::OP_CONNECT, 5'd2,  32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        offer_request(udp_sdt_pkg::OP_CONNECT, 5'd1,  32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        offer_request(udp_sdt_pkg::OP_LOOKUP,  5'd0,  32'hFFFF_FFFF, 16'hFFFF, FIRST_HOST_IP);
        drain_and_settle();

        // Random phases, each under its own local address
        for (int p = 0; p < PHASES; p++)
        begin
            write_local_ip(phase_ip[p]);
            tx_pace = phase_pace[p];
            rx_pace = phase_pace[p];
            repeat (PHASE_ITEMS)
                random_request(open_w[p], close_w[p], connect_w[p]);
            drain_and_settle();
        end

        $display("Run covered %0d requests: %0d open, %0d close, %0d connect, %0d lookup,",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("under %0d local address settings, with two long reply stalls.", ip_settings);
        if (fail_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== udp_socket_demux_table.f =====
+incdir+sv
sv/udp_sdt_pkg.sv
sv/udp_sdt_ram.sv
sv/udp_sdt_cmp.sv
sv/udp_socket_demux_table.sv
bench/udp_sdt_checker.sv
bench/tb.sv
